// ===== design/swept_box_collision_slide_defines.svh =====
// ----------------------------------------------------------------------------
// Swept box collision assertion macros
// Shared assertion forms for the swept box collision block.
// ----------------------------------------------------------------------------
`ifndef SWEPT_BOX_COLLISION_SLIDE_DEFINES_SVH
`define SWEPT_BOX_COLLISION_SLIDE_DEFINES_SVH

// The property holds in the same cycle as the condition.
`define SBCS_ASSERT_NOW(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

// The property holds in the cycle after the condition.
`define SBCS_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ===== design/sbcs_pkg.sv =====
// ----------------------------------------------------------------------------
// Swept box collision package
// Sizes, table record, datapath commands and saturation helper.
// ----------------------------------------------------------------------------
package sbcs_pkg;

  localparam int MAX_ENTRIES = 256;
  localparam int MAX_PASSES  = 4;
  localparam int FRAC_BITS   = 16;
  localparam int DT_FRAC     = 16;

  localparam int ENTRY_W   = $clog2(MAX_ENTRIES);
  localparam int COUNT_W   = $clog2(MAX_ENTRIES + 1);
  localparam int PASS_W    = $clog2(MAX_PASSES + 1);
  localparam int BIT_W     = $clog2(FRAC_BITS);
  localparam int T_W       = FRAC_BITS + 1;
  localparam int CONTACT_W = 3;
  localparam int MUL_W     = 33;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int WIDE_W    = 68;
  localparam int SAT_W     = 40;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int ACT_W     = 9;

  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EPSILON = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BACKOFF = 2'd2;

  typedef struct packed {
    logic               wall;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] box_left;
    logic signed [31:0] box_bottom;
    logic signed [31:0] box_right;
    logic signed [31:0] box_top;
  } entry_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_QUERY,
    OP_MV_LATCH,
    OP_DV_X,
    OP_DV_Y,
    OP_DV_END,
    OP_CENTRE,
    OP_PATH,
    OP_ENT_LATCH,
    OP_EDGE,
    OP_M1,
    OP_M2,
    OP_M3,
    OP_M4,
    OP_M5,
    OP_M6,
    OP_M7,
    OP_NORM,
    OP_TEST,
    OP_DIV,
    OP_UPD,
    OP_GMUL,
    OP_GPOS,
    OP_FMULX,
    OP_FX,
    OP_FY,
    OP_WB,
    OP_OUT
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [ENTRY_W-1:0] addr;
    logic [1:0]         side;
  } cmd_t;

  typedef struct packed {
    logic skip;
    logic full;
    logic hit_wall;
  } status_t;

  function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
    logic signed [SAT_W-1:0] hi_lim;
    logic signed [SAT_W-1:0] lo_lim;
    hi_lim = SAT_W'(32'sh7FFFFFFF);
    lo_lim = SAT_W'(32'sh80000000);
    if (v > hi_lim) begin
      return 32'sh7FFFFFFF;
    end else if (v < lo_lim) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

endpackage

// ===== design/sbcs_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sbcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/sbcs_dp.sv =====
// ----------------------------------------------------------------------------
// Swept box collision datapath
// Box table, shared multiplier, cross products, divider and glide arithmetic.
// ----------------------------------------------------------------------------
module sbcs_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  sbcs_pkg::cmd_t                      cmd,
  output sbcs_pkg::status_t                   status,
  input  logic [7:0]                          in_entry_index,
  input  logic                                in_is_wall,
  input  logic signed [31:0]                  in_pos_x,
  input  logic signed [31:0]                  in_pos_y,
  input  logic signed [31:0]                  in_box_left,
  input  logic signed [31:0]                  in_box_bottom,
  input  logic signed [31:0]                  in_box_right,
  input  logic signed [31:0]                  in_box_top,
  input  logic signed [31:0]                  in_vel_x,
  input  logic signed [31:0]                  in_vel_y,
  input  logic [15:0]                         in_time_step,
  input  logic [sbcs_pkg::CFG_W-1:0]          parallel_epsilon,
  input  logic [sbcs_pkg::CFG_W-1:0]          backoff_distance,
  output logic signed [31:0]                  out_new_pos_x,
  output logic signed [31:0]                  out_new_pos_y,
  output logic signed [31:0]                  out_new_vel_x,
  output logic signed [31:0]                  out_new_vel_y,
  output logic [sbcs_pkg::CONTACT_W-1:0]      out_wall_contacts
);

  localparam int SW = sbcs_pkg::SAT_W;
  localparam int WW = sbcs_pkg::WIDE_W;
  localparam int MW = sbcs_pkg::MUL_W;
  localparam int PW = sbcs_pkg::PROD_W;
  localparam int TW = sbcs_pkg::T_W;
  localparam int FB = sbcs_pkg::FRAC_BITS;
  localparam int DF = sbcs_pkg::DT_FRAC;
  localparam int EW = sbcs_pkg::ENTRY_W;

  logic [EW-1:0]          idx_r;
  logic signed [31:0]     vel_r [2];
  logic [15:0]            dt_r;
  logic signed [31:0]     pos_r [2];
  logic signed [31:0]     low_r [2];
  logic signed [31:0]     high_r [2];
  logic signed [31:0]     half_r [2];
  logic                   wall_r;
  logic signed [32:0]     dv_r [2];
  logic signed [31:0]     c_r [2];
  logic signed [32:0]     u_r [2];
  logic signed [31:0]     ex0_r, ex1_r, ey0_r, ey1_r;
  logic                   ewall_r;
  logic signed [32:0]     vx_r, vy_r, wx_r, wy_r;
  logic signed [PW-1:0]   prod_r;
  logic signed [PW-1:0]   acc_r;
  logic signed [WW-1:0]   d_r, ns_r, nt_r;
  logic [WW-1:0]          rem_r;
  logic [TW-1:0]          q_r;
  logic                   best_valid_r;
  logic [TW-1:0]          best_t_r;
  logic                   best_axis_r;
  logic                   best_pos_r;
  logic                   best_wall_r;
  logic [sbcs_pkg::CONTACT_W-1:0] contacts_r;
  logic signed [31:0]     out_px_r, out_py_r, out_vx_r, out_vy_r;
  logic [sbcs_pkg::CONTACT_W-1:0] out_cnt_r;

  sbcs_pkg::entry_t       rd;
  sbcs_pkg::entry_t       wr;
  logic [$bits(sbcs_pkg::entry_t)-1:0] ram_rdata;
  logic                   ram_we;
  logic [EW-1:0]          ram_waddr;

  logic signed [MW-1:0]   mul_a, mul_b;
  logic signed [PW-1:0]   prod_nxt;
  logic signed [32:0]     hdx, hdy, hsx, hsy;
  logic signed [31:0]     ax, ay, bx, by;
  logic signed [WW-1:0]   thr;
  logic [WW-1:0]          r2;
  logic signed [32:0]     dvp;
  logic signed [33:0]     gstep;
  logic signed [16:0]     bo;
  logic signed [SW-1:0]   cen;

  assign ram_we    = (cmd.op == sbcs_pkg::OP_LOAD) || (cmd.op == sbcs_pkg::OP_WB);
  assign ram_waddr = (cmd.op == sbcs_pkg::OP_LOAD) ? in_entry_index[EW-1:0] : idx_r;

  always_comb begin
    if (cmd.op == sbcs_pkg::OP_LOAD) begin
      wr.wall       = in_is_wall;
      wr.pos_x      = in_pos_x;
      wr.pos_y      = in_pos_y;
      wr.box_left   = in_box_left;
      wr.box_bottom = in_box_bottom;
      wr.box_right  = in_box_right;
      wr.box_top    = in_box_top;
    end else begin
      wr.wall       = wall_r;
      wr.pos_x      = pos_r[0];
      wr.pos_y      = pos_r[1];
      wr.box_left   = low_r[0];
      wr.box_bottom = low_r[1];
      wr.box_right  = high_r[0];
      wr.box_top    = high_r[1];
    end
  end

  sbcs_ram #(
    .WIDTH ($bits(sbcs_pkg::entry_t)),
    .DEPTH (sbcs_pkg::MAX_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wr),
    .raddr (cmd.addr),
    .rdata (ram_rdata)
  );

  assign rd = sbcs_pkg::entry_t'(ram_rdata);

  // Half sizes rounded toward zero.
  assign hdx = 33'(rd.box_right) - 33'(rd.box_left);
  assign hdy = 33'(rd.box_top) - 33'(rd.box_bottom);
  assign hsx = hdx + $signed({32'd0, hdx[32]});
  assign hsy = hdy + $signed({32'd0, hdy[32]});

  always_comb begin
    unique case (cmd.side)
      2'd0: begin ax = ex0_r; ay = ey1_r; bx = ex1_r; by = ey1_r; end
      2'd1: begin ax = ex1_r; ay = ey0_r; bx = ex0_r; by = ey0_r; end
      2'd2: begin ax = ex0_r; ay = ey0_r; bx = ex0_r; by = ey1_r; end
      default: begin ax = ex1_r; ay = ey1_r; bx = ex1_r; by = ey0_r; end
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      sbcs_pkg::OP_DV_X, sbcs_pkg::OP_FMULX: begin
        mul_a = MW'(vel_r[0]);
        mul_b = $signed({17'd0, dt_r});
      end
      sbcs_pkg::OP_DV_Y, sbcs_pkg::OP_FX: begin
        mul_a = MW'(vel_r[1]);
        mul_b = $signed({17'd0, dt_r});
      end
      sbcs_pkg::OP_M1: begin mul_a = u_r[0]; mul_b = vy_r; end
      sbcs_pkg::OP_M2: begin mul_a = u_r[1]; mul_b = vx_r; end
      sbcs_pkg::OP_M3: begin mul_a = wx_r;   mul_b = u_r[1]; end
      sbcs_pkg::OP_M4: begin mul_a = wy_r;   mul_b = u_r[0]; end
      sbcs_pkg::OP_M5: begin mul_a = wx_r;   mul_b = vy_r; end
      sbcs_pkg::OP_M6: begin mul_a = wy_r;   mul_b = vx_r; end
      sbcs_pkg::OP_GMUL: begin
        mul_a = u_r[best_axis_r];
        mul_b = $signed({{(MW-TW){1'b0}}, best_t_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_nxt = mul_a * mul_b;
  assign dvp      = $signed(prod_r[DF+32:DF]);
  assign gstep    = $signed(prod_r[FB+33:FB]);
  assign bo       = $signed({1'b0, backoff_distance});
  assign cen      = SW'(c_r[best_axis_r]) + SW'(gstep) + (best_pos_r ? SW'(bo) : -SW'(bo));
  assign r2       = {rem_r[WW-2:0], 1'b0};
  assign thr      = $signed(WW'({parallel_epsilon, {FB{1'b0}}}));

  assign status.skip = (d_r == '0) || (d_r < thr) || ns_r[WW-1] || (d_r < ns_r) ||
                       nt_r[WW-1] || (d_r < nt_r);
  assign status.full = !(nt_r < d_r);
  assign status.hit_wall = best_valid_r && best_wall_r;

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (!rst_n) begin
      best_valid_r <= 1'b0;
      contacts_r   <= '0;
    end else begin
      unique case (cmd.op)
        sbcs_pkg::OP_QUERY: begin
          idx_r      <= in_entry_index[EW-1:0];
          vel_r[0]   <= in_vel_x;
          vel_r[1]   <= in_vel_y;
          dt_r       <= in_time_step;
          contacts_r <= '0;
        end
        sbcs_pkg::OP_MV_LATCH: begin
          pos_r[0]  <= rd.pos_x;
          pos_r[1]  <= rd.pos_y;
          low_r[0]  <= rd.box_left;
          low_r[1]  <= rd.box_bottom;
          high_r[0] <= rd.box_right;
          high_r[1] <= rd.box_top;
          wall_r    <= rd.wall;
          half_r[0] <= hsx[32:1];
          half_r[1] <= hsy[32:1];
        end
        sbcs_pkg::OP_DV_Y: dv_r[0] <= dvp;
        sbcs_pkg::OP_DV_END: dv_r[1] <= dvp;
        sbcs_pkg::OP_CENTRE: begin
          c_r[0] <= sbcs_pkg::sat32(SW'(low_r[0]) + SW'(pos_r[0]) + SW'(half_r[0]));
          c_r[1] <= sbcs_pkg::sat32(SW'(low_r[1]) + SW'(pos_r[1]) + SW'(half_r[1]));
        end
        sbcs_pkg::OP_PATH: begin
          u_r[0] <= 33'(sbcs_pkg::sat32(SW'(c_r[0]) + SW'(dv_r[0]))) - 33'(c_r[0]);
          u_r[1] <= 33'(sbcs_pkg::sat32(SW'(c_r[1]) + SW'(dv_r[1]))) - 33'(c_r[1]);
          best_valid_r <= 1'b0;
        end
        sbcs_pkg::OP_ENT_LATCH: begin
          ex0_r <= sbcs_pkg::sat32(SW'(rd.box_left) - SW'(half_r[0]) + SW'(rd.pos_x));
          ex1_r <= sbcs_pkg::sat32(SW'(rd.box_right) + SW'(half_r[0]) + SW'(rd.pos_x));
          ey0_r <= sbcs_pkg::sat32(SW'(rd.box_bottom) - SW'(half_r[1]) + SW'(rd.pos_y));
          ey1_r <= sbcs_pkg::sat32(SW'(rd.box_top) + SW'(half_r[1]) + SW'(rd.pos_y));
          ewall_r <= rd.wall;
        end
        sbcs_pkg::OP_EDGE: begin
          vx_r <= 33'(bx) - 33'(ax);
          vy_r <= 33'(by) - 33'(ay);
          wx_r <= 33'(ax) - 33'(c_r[0]);
          wy_r <= 33'(ay) - 33'(c_r[1]);
        end
        sbcs_pkg::OP_M2, sbcs_pkg::OP_M4, sbcs_pkg::OP_M6: acc_r <= prod_r;
        sbcs_pkg::OP_M3: d_r  <= WW'(acc_r) - WW'(prod_r);
        sbcs_pkg::OP_M5: ns_r <= WW'(acc_r) - WW'(prod_r);
        sbcs_pkg::OP_M7: nt_r <= WW'(acc_r) - WW'(prod_r);
        sbcs_pkg::OP_NORM: begin
          if (d_r[WW-1]) begin
            d_r  <= -d_r;
            ns_r <= -ns_r;
            nt_r <= -nt_r;
          end
        end
        sbcs_pkg::OP_TEST: begin
          if (status.full) begin
            q_r <= TW'(1) << FB;
          end else begin
            q_r   <= '0;
            rem_r <= nt_r;
          end
        end
        sbcs_pkg::OP_DIV: begin
          if (r2 >= d_r) begin
            rem_r <= r2 - d_r;
            q_r   <= {q_r[TW-2:0], 1'b1};
          end else begin
            rem_r <= r2;
            q_r   <= {q_r[TW-2:0], 1'b0};
          end
        end
        sbcs_pkg::OP_UPD: begin
          if (!best_valid_r || (q_r < best_t_r)) begin
            best_valid_r <= 1'b1;
            best_t_r     <= q_r;
            best_wall_r  <= ewall_r;
            if (vy_r == '0) begin
              best_axis_r <= 1'b1;
              best_pos_r  <= (vx_r > 0);
            end else begin
              best_axis_r <= 1'b0;
              best_pos_r  <= !(vy_r > 0);
            end
          end
        end
        sbcs_pkg::OP_GPOS: begin
          pos_r[best_axis_r] <= sbcs_pkg::sat32(cen - SW'(low_r[best_axis_r]) -
                                                SW'(half_r[best_axis_r]));
          vel_r[best_axis_r] <= '0;
          contacts_r         <= contacts_r + 1'b1;
        end
        sbcs_pkg::OP_FX: pos_r[0] <= sbcs_pkg::sat32(SW'(pos_r[0]) + SW'(dvp));
        sbcs_pkg::OP_FY: pos_r[1] <= sbcs_pkg::sat32(SW'(pos_r[1]) + SW'(dvp));
        sbcs_pkg::OP_OUT: begin
          out_px_r  <= pos_r[0];
          out_py_r  <= pos_r[1];
          out_vx_r  <= vel_r[0];
          out_vy_r  <= vel_r[1];
          out_cnt_r <= contacts_r;
        end
        default: begin
        end
      endcase
    end
  end

  assign out_new_pos_x     = out_px_r;
  assign out_new_pos_y     = out_py_r;
  assign out_new_vel_x     = out_vx_r;
  assign out_new_vel_y     = out_vy_r;
  assign out_wall_contacts = out_cnt_r;

endmodule

// ===== design/sbcs_ctrl.sv =====
// ----------------------------------------------------------------------------
// Swept box collision controller
// Sequences loads, passes, table scans, edge tests and the result hand-off.
// ----------------------------------------------------------------------------
`include "swept_box_collision_slide_defines.svh"

module sbcs_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_mode,
  input  logic [7:0]                     in_entry_index,
  output logic                           in_stall,
  output logic                           out_valid,
  input  logic                           out_stall,
  input  logic [sbcs_pkg::COUNT_W-1:0]   used,
  input  sbcs_pkg::status_t              status,
  output sbcs_pkg::cmd_t                 cmd
);

  localparam int EW = sbcs_pkg::ENTRY_W;
  localparam int CW = sbcs_pkg::COUNT_W;

  typedef enum logic [4:0] {
    S_IDLE, S_MV_READ, S_MV_LATCH, S_P_MULX, S_P_MULY, S_P_DVY, S_P_C, S_P_U,
    S_SCAN, S_ENT_LATCH, S_E_SETUP, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7,
    S_NORM, S_TEST, S_DIV, S_UPD, S_G_MUL, S_G_POS, S_F_MULX, S_F_X, S_F_Y,
    S_WB, S_OUT
  } state_t;

  state_t                       state_r;
  logic [CW-1:0]                j_r;
  logic [1:0]                   side_r;
  logic [sbcs_pkg::BIT_W-1:0]   bit_r;
  logic [sbcs_pkg::PASS_W-1:0]  pass_r;
  logic [EW-1:0]                m_r;
  logic                         out_valid_r;
  logic                         out_free;
  logic                         scan_done;
  logic                         is_mover;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign scan_done = (j_r >= used);
  assign is_mover  = (j_r[EW-1:0] == m_r);

  always_comb begin
    cmd.op   = sbcs_pkg::OP_NONE;
    cmd.addr = (state_r == S_MV_READ) ? m_r : j_r[EW-1:0];
    cmd.side = side_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = in_mode ? sbcs_pkg::OP_QUERY : sbcs_pkg::OP_LOAD;
        end
      end
      S_MV_LATCH:  cmd.op = sbcs_pkg::OP_MV_LATCH;
      S_P_MULX:    cmd.op = sbcs_pkg::OP_DV_X;
      S_P_MULY:    cmd.op = sbcs_pkg::OP_DV_Y;
      S_P_DVY:     cmd.op = sbcs_pkg::OP_DV_END;
      S_P_C:       cmd.op = sbcs_pkg::OP_CENTRE;
      S_P_U:       cmd.op = sbcs_pkg::OP_PATH;
      S_ENT_LATCH: cmd.op = sbcs_pkg::OP_ENT_LATCH;
      S_E_SETUP:   cmd.op = sbcs_pkg::OP_EDGE;
      S_M1:        cmd.op = sbcs_pkg::OP_M1;
      S_M2:        cmd.op = sbcs_pkg::OP_M2;
      S_M3:        cmd.op = sbcs_pkg::OP_M3;
      S_M4:        cmd.op = sbcs_pkg::OP_M4;
      S_M5:        cmd.op = sbcs_pkg::OP_M5;
      S_M6:        cmd.op = sbcs_pkg::OP_M6;
      S_M7:        cmd.op = sbcs_pkg::OP_M7;
      S_NORM:      cmd.op = sbcs_pkg::OP_NORM;
      S_TEST:      cmd.op = sbcs_pkg::OP_TEST;
      S_DIV:       cmd.op = sbcs_pkg::OP_DIV;
      S_UPD:       cmd.op = sbcs_pkg::OP_UPD;
      S_G_MUL:     cmd.op = sbcs_pkg::OP_GMUL;
      S_G_POS:     cmd.op = sbcs_pkg::OP_GPOS;
      S_F_MULX:    cmd.op = sbcs_pkg::OP_FMULX;
      S_F_X:       cmd.op = sbcs_pkg::OP_FX;
      S_F_Y:       cmd.op = sbcs_pkg::OP_FY;
      S_WB:        cmd.op = sbcs_pkg::OP_WB;
      S_OUT: begin
        if (out_free) begin
          cmd.op = sbcs_pkg::OP_OUT;
        end
      end
      default:     cmd.op = sbcs_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      j_r         <= '0;
      side_r      <= '0;
      bit_r       <= '0;
      pass_r      <= '0;
      m_r         <= '0;
    end else begin
      if ((state_r == S_OUT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid && in_mode) begin
            m_r     <= in_entry_index[EW-1:0];
            pass_r  <= '0;
            state_r <= S_MV_READ;
          end
        end
        S_MV_READ:  state_r <= S_MV_LATCH;
        S_MV_LATCH: state_r <= S_P_MULX;
        S_P_MULX:   state_r <= S_P_MULY;
        S_P_MULY:   state_r <= S_P_DVY;
        S_P_DVY:    state_r <= S_P_C;
        S_P_C:      state_r <= S_P_U;
        S_P_U: begin
          j_r     <= '0;
          state_r <= S_SCAN;
        end
        S_SCAN: begin
          if (scan_done) begin
            state_r <= status.hit_wall ? S_G_MUL : S_F_MULX;
          end else if (is_mover) begin
            j_r <= j_r + CW'(1);
          end else begin
            state_r <= S_ENT_LATCH;
          end
        end
        S_ENT_LATCH: begin
          side_r  <= '0;
          state_r <= S_E_SETUP;
        end
        S_E_SETUP: state_r <= S_M1;
        S_M1:      state_r <= S_M2;
        S_M2:      state_r <= S_M3;
        S_M3:      state_r <= S_M4;
        S_M4:      state_r <= S_M5;
        S_M5:      state_r <= S_M6;
        S_M6:      state_r <= S_M7;
        S_M7:      state_r <= S_NORM;
        S_NORM:    state_r <= S_TEST;
        S_TEST: begin
          if (status.skip) begin
            if (side_r == 2'd3) begin
              j_r     <= j_r + CW'(1);
              state_r <= S_SCAN;
            end else begin
              side_r  <= side_r + 2'd1;
              state_r <= S_E_SETUP;
            end
          end else if (status.full) begin
            state_r <= S_UPD;
          end else begin
            bit_r   <= '0;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (bit_r == sbcs_pkg::BIT_W'(sbcs_pkg::FRAC_BITS - 1)) begin
            state_r <= S_UPD;
          end else begin
            bit_r <= bit_r + 1'b1;
          end
        end
        S_UPD: begin
          if (side_r == 2'd3) begin
            j_r     <= j_r + CW'(1);
            state_r <= S_SCAN;
          end else begin
            side_r  <= side_r + 2'd1;
            state_r <= S_E_SETUP;
          end
        end
        S_G_MUL: state_r <= S_G_POS;
        S_G_POS: begin
          if (pass_r == sbcs_pkg::PASS_W'(sbcs_pkg::MAX_PASSES - 1)) begin
            state_r <= S_F_MULX;
          end else begin
            pass_r  <= pass_r + 1'b1;
            state_r <= S_P_MULX;
          end
        end
        S_F_MULX: state_r <= S_F_X;
        S_F_X:    state_r <= S_F_Y;
        S_F_Y:    state_r <= S_WB;
        S_WB:     state_r <= S_OUT;
        S_OUT: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `SBCS_ASSERT_NEXT(a_out_loaded, (state_r == S_OUT) && !out_valid_r, out_valid_r, "result not presented after completion")
  `SBCS_ASSERT_NOW(a_no_self_test, state_r == S_ENT_LATCH, (j_r < used) && (j_r[EW-1:0] != m_r), "mover tested against itself")
  `SBCS_ASSERT_NOW(a_glide_after_scan, state_r == S_G_MUL, $past(state_r) == S_SCAN, "glide started outside scan end")

endmodule

// ===== design/swept_box_collision_slide.sv =====
// ----------------------------------------------------------------------------
// Swept box collision with wall sliding
// Top level: configuration registers, controller and datapath.
// ----------------------------------------------------------------------------
// The input channel carries two kinds of request. A load request (mode 0)
// writes one table entry; it gives no result. A move
// request (mode 1) runs up to four passes over the table and gives one result
// on the output channel with the new position, velocity and contact count.
// Every edge test goes through one shared 33 by 33 bit multiplier, six
// products in turn, and a restoring divider of one quotient bit a cycle.
// An edge test ends in a skip, a full hit or a division; the mover's own entry
// is passed over. The block takes one request at a time; in_stall is high
// while a move runs. A finished result sits in the output register while the
// next request is taken, and the move after it waits only if that result is
// still stalled. Reset sets active_entries to 0 and both thresholds to 7;
// table contents are undefined until loaded. Configuration is to be written
// only while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module swept_box_collision_slide (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_mode,
  input  logic [7:0]                         in_entry_index,
  input  logic                               in_is_wall,
  input  logic signed [31:0]                 in_pos_x,
  input  logic signed [31:0]                 in_pos_y,
  input  logic signed [31:0]                 in_box_left,
  input  logic signed [31:0]                 in_box_bottom,
  input  logic signed [31:0]                 in_box_right,
  input  logic signed [31:0]                 in_box_top,
  input  logic signed [31:0]                 in_vel_x,
  input  logic signed [31:0]                 in_vel_y,
  input  logic [15:0]                        in_time_step,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [31:0]                 out_new_pos_x,
  output logic signed [31:0]                 out_new_pos_y,
  output logic signed [31:0]                 out_new_vel_x,
  output logic signed [31:0]                 out_new_vel_y,
  output logic [sbcs_pkg::CONTACT_W-1:0]     out_wall_contacts,
  input  logic                               cfg_we,
  input  logic [sbcs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sbcs_pkg::CFG_W-1:0]         cfg_wdata
);

  localparam int AW = sbcs_pkg::ACT_W;
  localparam int CW = sbcs_pkg::COUNT_W;

  logic [AW-1:0]               active_r;
  logic [sbcs_pkg::CFG_W-1:0]  epsilon_r;
  logic [sbcs_pkg::CFG_W-1:0]  backoff_r;
  logic [CW-1:0]               used;
  sbcs_pkg::cmd_t              cmd;
  sbcs_pkg::status_t           status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r  <= '0;
      epsilon_r <= sbcs_pkg::CFG_W'(7);
      backoff_r <= sbcs_pkg::CFG_W'(7);
    end else if (cfg_we) begin
      unique case (cfg_index)
        sbcs_pkg::REG_ACTIVE:  active_r  <= cfg_wdata[AW-1:0];
        sbcs_pkg::REG_EPSILON: epsilon_r <= cfg_wdata;
        sbcs_pkg::REG_BACKOFF: backoff_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign used = (32'(active_r) > sbcs_pkg::MAX_ENTRIES) ?
                CW'(sbcs_pkg::MAX_ENTRIES) : CW'(active_r);

  sbcs_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_mode        (in_mode),
    .in_entry_index (in_entry_index),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .used           (used),
    .status         (status),
    .cmd            (cmd)
  );

  sbcs_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .in_entry_index    (in_entry_index),
    .in_is_wall        (in_is_wall),
    .in_pos_x          (in_pos_x),
    .in_pos_y          (in_pos_y),
    .in_box_left       (in_box_left),
    .in_box_bottom     (in_box_bottom),
    .in_box_right      (in_box_right),
    .in_box_top        (in_box_top),
    .in_vel_x          (in_vel_x),
    .in_vel_y          (in_vel_y),
    .in_time_step      (in_time_step),
    .parallel_epsilon  (epsilon_r),
    .backoff_distance  (backoff_r),
    .out_new_pos_x     (out_new_pos_x),
    .out_new_pos_y     (out_new_pos_y),
    .out_new_vel_x     (out_new_vel_x),
    .out_new_vel_y     (out_new_vel_y),
    .out_wall_contacts (out_wall_contacts)
  );

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Swept box collision testbench
// Loads box tables, sends move requests under random stalls and checks every
// result against a bit-exact predictor of the sweep, glide and advance.
// ----------------------------------------------------------------------------
module tb;

  localparam int U = 65536;
  localparam longint I32_MAX = 64'sd2147483647;
  localparam longint I32_MIN = -64'sd2147483648;
  localparam int LIMIT = 4000000;
  localparam int NE = sbcs_pkg::MAX_ENTRIES;
  localparam int FB = sbcs_pkg::FRAC_BITS;
  localparam int CFW = sbcs_pkg::CFG_W;
  localparam bit MODE_LOAD = 1'b0;
  localparam bit MODE_MOVE = 1'b1;

  typedef enum {ROW_LOAD, ROW_MOVE, ROW_CFG} row_kind_t;
  typedef logic signed [127:0] w128_t;

  typedef struct {
    bit        mode;
    bit [7:0]  idx;
    bit        wall;
    int        px, py, bl, bb, br, bt, vx, vy;
    bit [15:0] dt;
  } req_t;

  typedef struct {
    int       px, py, vx, vy;
    bit [2:0] nc;
  } move_res_t;

  typedef struct {
    bit     ok;
    longint t;
    int     axis;
    int     sgn;
  } hit_t;

  typedef struct {
    row_kind_t kind;
    req_t      req;
    int        act, eps, bo;
    bit        has_exp;
    move_res_t exp;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_mode = 1'b0;
  logic [7:0] in_entry_index = '0;
  logic in_is_wall = 1'b0;
  logic signed [31:0] in_pos_x = '0, in_pos_y = '0;
  logic signed [31:0] in_box_left = '0, in_box_bottom = '0;
  logic signed [31:0] in_box_right = '0, in_box_top = '0;
  logic signed [31:0] in_vel_x = '0, in_vel_y = '0;
  logic [15:0] in_time_step = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic signed [31:0] out_new_pos_x, out_new_pos_y, out_new_vel_x, out_new_vel_y;
  logic [sbcs_pkg::CONTACT_W-1:0] out_wall_contacts;
  logic cfg_we = 1'b0;
  logic [sbcs_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFW-1:0] cfg_wdata = '0;

  swept_box_collision_slide uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state.
  int box_x[NE], box_y[NE];
  int box_l[NE], box_b[NE], box_r[NE], box_t[NE];
  bit box_wall[NE];
  bit loaded[NE];
  int act_reg = 0, eps_reg = 7, bo_reg = 7;

  move_res_t slide_q[$];
  int errs = 0, cycles = 0, n_loads = 0, n_moves = 0, n_results = 0, n_contacts = 0;
  int rx_seen = 0, hold_left = 0;
  bit hold_done = 0, tx_calm = 0;
  row_t rows[$];

  function automatic longint clamp32(longint v);
    if (v > I32_MAX) return I32_MAX;
    if (v < I32_MIN) return I32_MIN;
    return v;
  endfunction

  function automatic void edge_hit(input longint cx, cy, ux, uy, ax, ay, bx, by,
                                   inout hit_t h);
    longint ex, ey, wx, wy, q;
    w128_t d, ns, nt, thr;
    ex = bx - ax;
    ey = by - ay;
    wx = ax - cx;
    wy = ay - cy;
    d  = w128_t'(ux) * w128_t'(ey) - w128_t'(uy) * w128_t'(ex);
    ns = w128_t'(wx) * w128_t'(uy) - w128_t'(wy) * w128_t'(ux);
    nt = w128_t'(wx) * w128_t'(ey) - w128_t'(wy) * w128_t'(ex);
    thr = w128_t'(eps_reg) <<< FB;
    if (d < 0) begin
      d = -d;
      ns = -ns;
      nt = -nt;
    end
    if (d == 0 || d < thr) return;
    if (ns < 0 || ns > d || nt < 0 || nt > d) return;
    if (nt >= d) q = longint'(1) << FB;
    else q = longint'((nt <<< FB) / d);
    if (!h.ok || q < h.t) begin
      h.ok = 1;
      h.t = q;
      if (ey == 0) begin
        h.axis = 1;
        h.sgn = (ex > 0) ? 1 : -1;
      end else begin
        h.axis = 0;
        h.sgn = (ey > 0) ? -1 : 1;
      end
    end
  endfunction

  function automatic move_res_t slide_move(req_t r);
    int m, used;
    longint dt, x0, y0, x1, y1, ctr;
    longint vel[2], p[2], lo[2], hf[2], c[2], u[2];
    hit_t best, cr;
    bit wall;
    move_res_t res;
    m = r.idx;
    used = (act_reg < NE) ? act_reg : NE;
    dt = longint'(r.dt);
    vel[0] = r.vx;
    vel[1] = r.vy;
    p[0] = box_x[m];
    p[1] = box_y[m];
    lo[0] = box_l[m];
    lo[1] = box_b[m];
    hf[0] = (longint'(box_r[m]) - lo[0]) / 2;
    hf[1] = (longint'(box_t[m]) - lo[1]) / 2;
    res.nc = 0;
    for (int pass = 0; pass < sbcs_pkg::MAX_PASSES; pass++) begin
      best = '{0, 0, 0, 1};
      wall = 0;
      for (int k = 0; k < 2; k++) begin
        c[k] = clamp32(lo[k] + p[k] + hf[k]);
        u[k] = clamp32(c[k] + ((vel[k] * dt) >>> 16)) - c[k];
      end
      for (int j = 0; j < used; j++) begin
        if (j == m) continue;
        x0 = clamp32(longint'(box_l[j]) - hf[0] + box_x[j]);
        x1 = clamp32(longint'(box_r[j]) + hf[0] + box_x[j]);
        y0 = clamp32(longint'(box_b[j]) - hf[1] + box_y[j]);
        y1 = clamp32(longint'(box_t[j]) + hf[1] + box_y[j]);
        cr = '{0, 0, 0, 1};
        edge_hit(c[0], c[1], u[0], u[1], x0, y1, x1, y1, cr);
        edge_hit(c[0], c[1], u[0], u[1], x1, y0, x0, y0, cr);
        edge_hit(c[0], c[1], u[0], u[1], x0, y0, x0, y1, cr);
        edge_hit(c[0], c[1], u[0], u[1], x1, y1, x1, y0, cr);
        if (cr.ok && (!best.ok || cr.t < best.t)) begin
          best = cr;
          wall = box_wall[j];
        end
      end
      if (!best.ok || !wall) break;
      ctr = c[best.axis] + ((u[best.axis] * best.t) >>> FB)
          + ((best.sgn > 0) ? longint'(bo_reg) : -longint'(bo_reg));
      p[best.axis] = clamp32(ctr - lo[best.axis] - hf[best.axis]);
      vel[best.axis] = 0;
      res.nc++;
    end
    for (int k = 0; k < 2; k++) p[k] = clamp32(p[k] + ((vel[k] * dt) >>> 16));
    box_x[m] = int'(p[0]);
    box_y[m] = int'(p[1]);
    res.px = int'(p[0]);
    res.py = int'(p[1]);
    res.vx = int'(vel[0]);
    res.vy = int'(vel[1]);
    return res;
  endfunction

  function automatic req_t ld(int idx, bit wall, int px, int py, int l, int b, int r, int t);
    req_t q;
    q = '{MODE_LOAD, idx[7:0], wall, px, py, l, b, r, t, 0, 0, 0};
    return q;
  endfunction

  function automatic req_t mv(int idx, int vx, int vy, int dt);
    req_t q;
    q = '{MODE_MOVE, idx[7:0], $urandom_range(1), $urandom, $urandom, $urandom, $urandom,
          $urandom, $urandom, vx, vy, dt[15:0]};
    return q;
  endfunction

  function automatic row_t row_of(row_kind_t kind, req_t q);
    row_t rw;
    rw.kind = kind;
    rw.req = q;
    rw.has_exp = 0;
    return rw;
  endfunction

  function automatic req_t rand_box(int idx);
    int hw, hh, off;
    hw = $urandom_range(4 * U, U / 2);
    hh = $urandom_range(4 * U, U / 2);
    off = ($urandom_range(3) == 0) ? int'($urandom_range(2 * U)) - U : 0;
    return ld(idx, $urandom_range(99) < 80, int'($urandom_range(32 * U)) - 16 * U,
              int'($urandom_range(32 * U)) - 16 * U, off - hw, off - hh, off + hw, off + hh);
  endfunction

  function automatic int pick_mover();
    int i;
    if ($urandom_range(99) < 15) begin
      for (int n = 0; n < 16; n++) begin
        i = $urandom_range(NE - 1);
        if (loaded[i]) return i;
      end
    end
    return $urandom_range(act_reg - 1);
  endfunction

  function automatic req_t rand_move(int idx);
    int vx, vy;
    vx = ($urandom_range(4) == 0) ? 0 : int'($urandom_range(80 * U)) - 40 * U;
    vy = ($urandom_range(4) == 0) ? 0 : int'($urandom_range(80 * U)) - 40 * U;
    return mv(idx, vx, vy, ($urandom_range(5) == 0) ? $urandom_range(65535, 1) : 16'hFFFF);
  endfunction

  task automatic push_req(req_t r, bit has_exp, move_res_t exp);
    move_res_t pred;
    if (!tx_calm) begin
      while ($urandom_range(99) < 23) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_mode <= r.mode;
    in_entry_index <= r.idx;
    in_is_wall <= r.wall;
    in_pos_x <= r.px;
    in_pos_y <= r.py;
    in_box_left <= r.bl;
    in_box_bottom <= r.bb;
    in_box_right <= r.br;
    in_box_top <= r.bt;
    in_vel_x <= r.vx;
    in_vel_y <= r.vy;
    in_time_step <= r.dt;
    do @(posedge clk); while (in_stall);
    if (r.mode == MODE_LOAD) begin
      box_wall[r.idx] = r.wall;
      box_x[r.idx] = r.px;
      box_y[r.idx] = r.py;
      box_l[r.idx] = r.bl;
      box_b[r.idx] = r.bb;
      box_r[r.idx] = r.br;
      box_t[r.idx] = r.bt;
      loaded[r.idx] = 1;
      n_loads++;
    end else begin
      pred = slide_move(r);
      slide_q.push_back(has_exp ? exp : pred);
      n_moves++;
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (slide_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_config(int act, int eps, int bo);
    cfg_we <= 1'b1;
    cfg_index <= sbcs_pkg::REG_ACTIVE;
    cfg_wdata <= act[CFW-1:0];
    @(posedge clk);
    cfg_index <= sbcs_pkg::REG_EPSILON;
    cfg_wdata <= eps[CFW-1:0];
    @(posedge clk);
    cfg_index <= sbcs_pkg::REG_BACKOFF;
    cfg_wdata <= bo[CFW-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    act_reg = act;
    eps_reg = eps;
    bo_reg = bo;
  endtask

  always @(posedge clk) begin
    move_res_t e;
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      rx_seen++;
      if (slide_q.size() == 0) begin
        $error("result with no request outstanding");
        errs++;
      end else begin
        e = slide_q.pop_front();
        n_contacts += e.nc;
        if (out_new_pos_x !== e.px) begin
          $error("new_pos_x: expected %0d, got %0d", e.px, out_new_pos_x);
          errs++;
        end
        if (out_new_pos_y !== e.py) begin
          $error("new_pos_y: expected %0d, got %0d", e.py, out_new_pos_y);
          errs++;
        end
        if (out_new_vel_x !== e.vx) begin
          $error("new_vel_x: expected %0d, got %0d", e.vx, out_new_vel_x);
          errs++;
        end
        if (out_new_vel_y !== e.vy) begin
          $error("new_vel_y: expected %0d, got %0d", e.vy, out_new_vel_y);
          errs++;
        end
        if (out_wall_contacts !== e.nc) begin
          $error("wall_contacts: expected %0d, got %0d", e.nc, out_wall_contacts);
          errs++;
        end
      end
    end
    if (rx_seen == 30 && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= 20000;
    end
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !(rx_seen >= 60 && rx_seen < 80) && ($urandom_range(99) < 23);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int act_list[6], eps_list[6], bo_list[6];
    int roll;
    row_t rw;
    move_res_t none;

    none = '{0, 0, 0, 0, 0};
    act_list = '{1, 4, 8, 12, 3, 6};
    eps_list = '{0, 7, 16'hFFFF, 300, 7, 0};
    bo_list  = '{16'hFFFF, 7, 0, 1000, 7, 0};
    act_list[4] = $urandom_range(10, 2);
    eps_list[3] = $urandom_range(65535);
    bo_list[3] = $urandom_range(65535);

    rows.push_back(row_of(ROW_LOAD, ld(0, 0, 0, 0, -U, -U, U, U)));
    rw = row_of(ROW_MOVE, mv(0, 5 * U, 0, 0));
    rw.has_exp = 1;
    rw.exp = '{0, 0, 5 * U, 0, 0};
    rows.push_back(rw);
    rw = row_of(ROW_MOVE, mv(0, U, 2 * U, 16'h8000));
    rw.has_exp = 1;
    rw.exp = '{32'h8000, 32'h10000, U, 2 * U, 0};
    rows.push_back(rw);
    rows.push_back(row_of(ROW_MOVE, mv(0, 32'h7FFFFFFF, 32'h80000000, 16'hFFFF)));
    rows.push_back(row_of(ROW_LOAD, ld(255, 1, 32'h7FFFFFFF, 32'h80000000, 32'h80000000,
                                       32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF)));
    rows.push_back(row_of(ROW_MOVE, mv(255, -3 * U, 7 * U, 16'hFFFF)));
    rw = row_of(ROW_CFG, ld(0, 0, 0, 0, 0, 0, 0, 0));
    rw.act = 6;
    rw.eps = 7;
    rw.bo = 7;
    rows.push_back(rw);
    rows.push_back(row_of(ROW_LOAD, ld(0, 0, 0, 0, -U, -U, U, U)));
    rows.push_back(row_of(ROW_LOAD, ld(1, 1, 5 * U, 0, -U, -2 * U, U, 2 * U)));
    rows.push_back(row_of(ROW_LOAD, ld(2, 0, 0, 6 * U, -2 * U, -U, 2 * U, U)));
    rows.push_back(row_of(ROW_LOAD, ld(3, 1, -6 * U, -6 * U, -2 * U, -2 * U, 2 * U, 2 * U)));
    rows.push_back(row_of(ROW_LOAD, ld(4, 1, 0, -5 * U, -8 * U, -U, 8 * U, U)));
    rows.push_back(row_of(ROW_LOAD, ld(5, 1, -6 * U, 0, -U, -8 * U, U, 8 * U)));
    rows.push_back(row_of(ROW_MOVE, mv(0, 10 * U, 0, 16'hFFFF)));
    rows.push_back(row_of(ROW_MOVE, mv(0, 0, 10 * U, 16'hFFFF)));
    rows.push_back(row_of(ROW_MOVE, mv(0, -10 * U, -10 * U, 16'hFFFF)));
    rows.push_back(row_of(ROW_LOAD, ld(200, 0, 0, 0, -U, -U, U, U)));
    rows.push_back(row_of(ROW_MOVE, mv(200, 3 * U, -9 * U, 16'hFFFF)));
    rw.eps = 0;
    rw.bo = 0;
    rows.push_back(rw);
    rows.push_back(row_of(ROW_MOVE, mv(0, 9 * U, 0, 16'hC000)));
    rw.eps = 16'hFFFF;
    rw.bo = 16'hFFFF;
    rows.push_back(rw);
    rows.push_back(row_of(ROW_MOVE, mv(0, -10 * U, 4 * U, 16'hFFFF)));
    rows.push_back(row_of(ROW_MOVE, mv(0, 0, 0, 16'hFFFF)));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) begin
        drain();
        set_config(rows[i].act, rows[i].eps, rows[i].bo);
      end else begin
        push_req(rows[i].req, rows[i].has_exp, rows[i].exp);
      end
    end

    for (int ph = 0; ph < 6; ph++) begin
      drain();
      set_config(act_list[ph], eps_list[ph], bo_list[ph]);
      tx_calm = (ph == 2);
      for (int j = 0; j < act_reg; j++) if (!loaded[j]) push_req(rand_box(j), 0, none);
      for (int n = 0; n < 20; n++) begin
        roll = $urandom_range(99);
        if (roll < 8) begin
          push_req(ld($urandom_range(255), $urandom_range(1), $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom), 0, none);
        end else if (roll < 38) begin
          push_req(rand_box(($urandom_range(5) == 0) ? $urandom_range(255)
                                                     : $urandom_range(act_reg - 1)), 0, none);
        end else if (roll < 46) begin
          push_req(mv(pick_mover(), $urandom, $urandom, $urandom_range(65535)), 0, none);
        end else begin
          push_req(rand_move(pick_mover()), 0, none);
        end
      end
    end
    tx_calm = 0;

    drain();
    repeat (50) @(posedge clk);
    $display("covered %0d load and %0d move requests, %0d results, %0d wall glides",
             n_loads, n_moves, n_results, n_contacts);
    $display("active table sizes from 0 to 12 entries, %0d cycles", cycles);
    if (errs == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/sbcs_pkg.sv
design/sbcs_ram.sv
design/sbcs_dp.sv
design/sbcs_ctrl.sv
design/swept_box_collision_slide.sv
dv/tb.sv
